/* design/crf_pkg.sv */
package crf_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN = 24;
  localparam int AW = 17;                 // angle width, Q8.8 degrees
  localparam int CW = 34;                 // cordic x/y width (16 bit << 8, growth)
  localparam int ZW = 28;                 // cordic z width, Q11.16 degrees
  localparam int SW = $clog2(ATAN_LEN);
  localparam int MW = 18;                 // multiplier operand width of the serial multiplier
  localparam int PW = 40;                 // product accumulator width
  localparam int MCW = $clog2(MW + 1);

  localparam logic signed [AW-1:0] DEG180 = 17'sd46080;
  localparam logic signed [AW+1:0] DEG360 = 19'sd92160;

  localparam logic [1:0] REG_BLEND  = 2'd0;
  localparam logic [1:0] REG_PERIOD = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INC,
    ST_CORDIC,
    ST_MIX_A,
    ST_MIX_B,
    ST_OUT
  } state_t;

  // bit-serial multiply request and status
  typedef struct packed {
    logic                 start;
    logic signed [PW-1:0] a;
    logic [MW-1:0]        b;
  } mul_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [PW-1:0] prod;
  } mul_rsp_t;

  function automatic logic [ZW-1:0] atan_q16(input logic [SW-1:0] i);
    case (i)
      5'd0: atan_q16 = 28'd2949120;
      5'd1: atan_q16 = 28'd1740967;
      5'd2: atan_q16 = 28'd919879;
      5'd3: atan_q16 = 28'd466945;
      5'd4: atan_q16 = 28'd234379;
      5'd5: atan_q16 = 28'd117304;
      5'd6: atan_q16 = 28'd58666;
      5'd7: atan_q16 = 28'd29335;
      5'd8: atan_q16 = 28'd14668;
      5'd9: atan_q16 = 28'd7334;
      5'd10: atan_q16 = 28'd3667;
      5'd11: atan_q16 = 28'd1833;
      5'd12: atan_q16 = 28'd917;
      5'd13: atan_q16 = 28'd458;
      5'd14: atan_q16 = 28'd229;
      5'd15: atan_q16 = 28'd115;
      5'd16: atan_q16 = 28'd57;
      5'd17: atan_q16 = 28'd29;
      5'd18: atan_q16 = 28'd14;
      5'd19: atan_q16 = 28'd7;
      5'd20: atan_q16 = 28'd4;
      5'd21: atan_q16 = 28'd2;
      5'd22: atan_q16 = 28'd1;
      default: atan_q16 = '0;
    endcase
  endfunction

  // single wrap by 360 then clamp to +/-180
  function automatic logic signed [AW-1:0] wrap(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] w;
    w = v;
    if (v > PW'(DEG180)) w = v - PW'(DEG360);
    else if (v < -PW'(DEG180)) w = v + PW'(DEG360);
    if (w > PW'(DEG180)) w = PW'(DEG180);
    if (w < -PW'(DEG180)) w = -PW'(DEG180);
    wrap = w[AW-1:0];
  endfunction

endpackage

/* design/complementary_roll_filter.sv */
// channel  direction  handshake       payload
// in       input      valid / stall   gyro_rate, accel_y, accel_z
// out      output     valid / stall   fused_angle, gyro_angle, accel_roll
// cfg      input      valid / ready   index, data
// one item runs from its input transfer to the next possible transfer through
// the increment multiply (18 bit steps in a shared shift-and-add unit) with 16
// cordic steps in parallel with it, a hand-off state, two blend multiplies, the
// load of the output register and a return to idle, where the next input can
// be taken.
// reset is synchronous and restores the register defaults and zero state.
// a result waits in the output register while out_stall is high; the next item
// is computed meanwhile and then holds the input stalled until that register
// is free.
module complementary_roll_filter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [15:0]              gyro_rate,
  input  logic signed [15:0]              accel_y,
  input  logic signed [15:0]              accel_z,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [crf_pkg::AW-1:0]   fused_angle,
  output logic signed [crf_pkg::AW-1:0]   gyro_angle,
  output logic signed [crf_pkg::AW-1:0]   accel_roll,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [16:0]                     cfg_data
);

  crf_pkg::state_t state, state_next;
  crf_pkg::mul_req_t mreq;
  crf_pkg::mul_rsp_t mrsp;

  logic [15:0] blend_weight, sample_period;
  logic signed [crf_pkg::AW-1:0] roll_offset;
  logic signed [15:0] last_rate, rate;
  logic signed [crf_pkg::AW-1:0] last_gyro, last_fused, gyro_new;
  logic signed [crf_pkg::PW-1:0] inc, mix;
  logic signed [crf_pkg::AW-1:0] roll;
  logic cstart, cdone, cdone_seen;
  logic out_free;
  logic signed [crf_pkg::AW+1:0] cangle;
  logic signed [crf_pkg::PW-1:0] inc_calc, mix_sum;

  crf_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));
  crf_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cstart), .num(accel_z), .den(accel_y),
    .done(cdone), .angle(cangle)
  );

  assign cfg_ready = 1'b1;
  assign in_stall = (state != crf_pkg::ST_IDLE);
  assign cstart = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign inc_calc = (mrsp.prod + crf_pkg::PW'(16384)) >>> 15;
  assign mix_sum = mix + mrsp.prod + crf_pkg::PW'(32768);

  always_comb begin
    state_next = state;
    case (state)
      crf_pkg::ST_IDLE:   if (cstart) state_next = crf_pkg::ST_INC;
      crf_pkg::ST_INC:    if (mrsp.done) state_next = crf_pkg::ST_CORDIC;
      crf_pkg::ST_CORDIC: if (cdone || cdone_seen) state_next = crf_pkg::ST_MIX_A;
      crf_pkg::ST_MIX_A:  if (mrsp.done) state_next = crf_pkg::ST_MIX_B;
      crf_pkg::ST_MIX_B:  if (mrsp.done) state_next = crf_pkg::ST_OUT;
      crf_pkg::ST_OUT:    if (out_free) state_next = crf_pkg::ST_IDLE;
      default:            state_next = crf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mreq.start = 1'b0;
    mreq.a = '0;
    mreq.b = '0;
    case (state)
      crf_pkg::ST_IDLE: begin
        mreq.start = cstart;
        mreq.a = crf_pkg::PW'(last_rate) + crf_pkg::PW'(gyro_rate);
        mreq.b = crf_pkg::MW'(sample_period);
      end
      crf_pkg::ST_CORDIC: begin
        mreq.start = cdone || cdone_seen;
        mreq.a = crf_pkg::PW'(last_fused) - inc;
        mreq.b = crf_pkg::MW'(blend_weight);
      end
      crf_pkg::ST_MIX_A: begin
        mreq.start = mrsp.done;
        mreq.a = crf_pkg::PW'(roll);
        mreq.b = crf_pkg::MW'(18'd65536 - crf_pkg::MW'(blend_weight));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crf_pkg::ST_IDLE;
      blend_weight <= 16'd64225;
      sample_period <= 16'd655;
      roll_offset <= -17'sd23040;
      last_rate <= '0;
      last_gyro <= '0;
      last_fused <= '0;
      cdone_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        case (cfg_index)
          crf_pkg::REG_BLEND:  blend_weight <= cfg_data[15:0];
          crf_pkg::REG_PERIOD: sample_period <= cfg_data[15:0];
          crf_pkg::REG_OFFSET: roll_offset <= cfg_data;
          default: ;
        endcase
      end
      if (cstart) begin
        rate <= gyro_rate;
        cdone_seen <= 1'b0;
      end
      if (cdone) begin
        cdone_seen <= 1'b1;
        roll <= crf_pkg::wrap(crf_pkg::PW'(cangle) + crf_pkg::PW'(roll_offset));
      end
      if (state == crf_pkg::ST_INC && mrsp.done) begin
        inc <= inc_calc;
        gyro_new <= crf_pkg::wrap(crf_pkg::PW'(last_gyro) - inc_calc);
      end
      if (state == crf_pkg::ST_MIX_A && mrsp.done) mix <= mrsp.prod;
      if (state == crf_pkg::ST_MIX_B && mrsp.done) begin
        last_fused <= crf_pkg::wrap(mix_sum >>> 16);
        last_gyro <= gyro_new;
        last_rate <= rate;
      end
      // output register takes the finished item once it is empty or transferring
      if (state == crf_pkg::ST_OUT && out_free) begin
        out_valid <= 1'b1;
        fused_angle <= last_fused;
        gyro_angle <= last_gyro;
        accel_roll <= roll;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* design/crf_mul.sv */
module crf_mul (
  input  logic              clk,
  input  logic              rst,
  input  crf_pkg::mul_req_t req,
  output crf_pkg::mul_rsp_t rsp
);

  logic signed [crf_pkg::PW-1:0] a;
  logic [crf_pkg::MW-1:0]        b;
  logic signed [crf_pkg::PW-1:0] acc;
  logic [crf_pkg::MCW-1:0]       cnt;
  logic                          busy;
  logic                          done;

  // shift-and-add, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        a <= req.a;
        b <= req.b;
        acc <= '0;
        cnt <= '0;
      end else if (busy) begin
        if (b[0]) acc <= acc + a;
        a <= a <<< 1;
        b <= b >> 1;
        cnt <= cnt + 1'b1;
        if (cnt == crf_pkg::MCW'(crf_pkg::MW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done, prod: acc};

endmodule

/* design/crf_cordic.sv */
module crf_cordic (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [15:0]             num,
  input  logic signed [15:0]             den,
  output logic                           done,
  output logic signed [crf_pkg::AW+1:0]  angle
);

  logic signed [crf_pkg::CW-1:0] x, y;
  logic signed [crf_pkg::ZW-1:0] z;
  logic [crf_pkg::SW-1:0]        step;
  logic                          busy, zero;
  logic signed [crf_pkg::CW-1:0] xs, ys;
  logic signed [crf_pkg::ZW-1:0] at, zr;

  assign xs = x >>> step;
  assign ys = y >>> step;
  assign at = $signed(crf_pkg::atan_q16(step));
  assign zr = z + crf_pkg::ZW'(128);
  assign angle = zero ? '0 : (crf_pkg::AW+2)'(zr >>> 8);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        zero <= (num == 0) && (den == 0);
        if (den < 0) begin
          x <= -(crf_pkg::CW'(den) <<< 8);
          y <= -(crf_pkg::CW'(num) <<< 8);
          z <= (num >= 0) ? crf_pkg::ZW'(46080 * 256) : -crf_pkg::ZW'(46080 * 256);
        end else begin
          x <= crf_pkg::CW'(den) <<< 8;
          y <= crf_pkg::CW'(num) <<< 8;
          z <= '0;
        end
      end else if (busy) begin
        if (y > 0) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end
        step <= step + 1'b1;
        if (step == crf_pkg::SW'(crf_pkg::CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
